// ===== sv/ssa_pkg.sv =====
package ssa_pkg;

  localparam int SLOTS        = 256;
  localparam int MAX_ELEMENTS = 64;
  localparam int SLOT_W       = $clog2(SLOTS);
  localparam int ELEM_W       = $clog2(MAX_ELEMENTS);
  localparam int ACC_DEPTH    = SLOTS * MAX_ELEMENTS;
  localparam int ACC_AW       = $clog2(ACC_DEPTH);
  localparam int USED_W       = ELEM_W + 1;

  localparam int WORKERS_W = 8;
  localparam int UPDATES_W = 6;
  localparam int SEQ_W     = 32;
  localparam int DATA_W    = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_WORKERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_UPDATES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SEQ_NUM = 2'd2;

  localparam logic [WORKERS_W-1:0] NUM_WORKERS_RST = 8'd1;
  localparam logic [UPDATES_W-1:0] NUM_UPDATES_RST = 6'd32;
  localparam logic [SEQ_W-1:0]     MAX_SEQ_NUM_RST = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [WORKERS_W-1:0] num_workers;
    logic [UPDATES_W-1:0] num_updates;
    logic [SEQ_W-1:0]     max_seq_num;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  // Number of elements in use: twice the pair count, with zero pairs read as one,
  // clamped to the element capacity of a slot.
  function automatic logic [USED_W-1:0] elements_in_use(input logic [UPDATES_W-1:0] pairs);
    logic [UPDATES_W-1:0] p;
    logic [UPDATES_W:0]   n;
    p = (pairs == '0) ? UPDATES_W'(1) : pairs;
    n = {p, 1'b0};
    if (n > (UPDATES_W + 1)'(MAX_ELEMENTS)) begin
      n = (UPDATES_W + 1)'(MAX_ELEMENTS);
    end
    return USED_W'(n);
  endfunction

endpackage

// ===== sv/ssa_ram.sv =====
module ssa_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read and a write to the same entry in one cycle return the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ssa_ctrl.sv =====
module ssa_ctrl import ssa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [SLOT_W-1:0]    slot,
  input  logic [ELEM_W-1:0]    element,
  input  logic [DATA_W-1:0]    update_value,
  input  logic                 message_end,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [SLOT_W-1:0]    out_slot,
  output logic [ELEM_W-1:0]    out_element,
  output logic [DATA_W-1:0]    sum_value,
  output logic [SEQ_W-1:0]     sequence_res,
  output logic                 run_end
);

  state_t state, state_next;

  logic [ACC_AW-1:0] clr_addr;
  logic [ELEM_W-1:0] emit_idx;
  logic [SEQ_W-1:0]  seq;

  logic [SLOT_W-1:0] slot_r;
  logic [ELEM_W-1:0] elem_r;
  logic [DATA_W-1:0] value_r;
  logic              end_r;

  logic              acc_we, acc_re;
  logic [ACC_AW-1:0] acc_waddr, acc_raddr;
  logic [DATA_W-1:0] acc_wdata, acc_rdata;

  logic                 cnt_we, cnt_re;
  logic [SLOT_W-1:0]    cnt_waddr;
  logic [WORKERS_W-1:0] cnt_wdata, cnt_rdata;

  logic [USED_W-1:0]    used;
  logic [WORKERS_W-1:0] need;
  logic [WORKERS_W:0]   cnt_inc;
  logic                 done_msg;
  logic                 emit_last;
  logic                 out_free;
  logic                 out_load;
  logic                 seq_adv;
  logic [SEQ_W:0]       seq_inc;

  ssa_ram #(.DEPTH(ACC_DEPTH), .WIDTH(DATA_W)) u_acc (
    .clk   (clk),
    .we    (acc_we),
    .waddr (acc_waddr),
    .wdata (acc_wdata),
    .re    (acc_re),
    .raddr (acc_raddr),
    .rdata (acc_rdata)
  );

  ssa_ram #(.DEPTH(SLOTS), .WIDTH(WORKERS_W)) u_cnt (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (slot),
    .rdata (cnt_rdata)
  );

  assign used      = elements_in_use(cfg.num_updates);
  assign need      = (cfg.num_workers == '0) ? WORKERS_W'(1) : cfg.num_workers;
  assign cnt_inc   = {1'b0, cnt_rdata} + (WORKERS_W + 1)'(1);
  assign done_msg  = cnt_inc >= {1'b0, need};
  assign emit_last = ({1'b0, emit_idx} + USED_W'(1)) == used;
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE);
  assign seq_inc   = {1'b0, seq} + (SEQ_W + 1)'(1);

  always_comb begin
    state_next = state;
    acc_we     = 1'b0;
    acc_re     = 1'b0;
    acc_waddr  = {slot_r, elem_r};
    acc_raddr  = {slot, element};
    acc_wdata  = acc_rdata + value_r;
    cnt_we     = 1'b0;
    cnt_re     = 1'b0;
    cnt_waddr  = slot_r;
    cnt_wdata  = '0;
    out_load   = 1'b0;
    seq_adv    = 1'b0;
    case (state)
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_addr;
        acc_wdata = '0;
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr[ACC_AW-1:ELEM_W];
        if (clr_addr == ACC_AW'(ACC_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        acc_re = in_valid;
        cnt_re = in_valid;
        if (in_valid) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        acc_we = ({1'b0, elem_r} < used);
        state_next = ST_IDLE;
        if (end_r) begin
          cnt_we = 1'b1;
          if (done_msg) begin
            cnt_wdata  = '0;
            state_next = ST_EMIT_RD;
          end else begin
            cnt_wdata = cnt_inc[WORKERS_W-1:0];
          end
        end
      end
      ST_EMIT_RD: begin
        // Read the sum and zero the entry in the same cycle.
        acc_re     = 1'b1;
        acc_raddr  = {slot_r, emit_idx};
        acc_we     = 1'b1;
        acc_waddr  = {slot_r, emit_idx};
        acc_wdata  = '0;
        state_next = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (emit_last) begin
            seq_adv    = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      emit_idx <= '0;
      seq      <= '0;
    end else begin
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + ACC_AW'(1);
      end
      if (state == ST_ADD) begin
        emit_idx <= '0;
      end else if (out_load) begin
        emit_idx <= emit_idx + ELEM_W'(1);
      end
      if (seq_adv) begin
        // Wrap to zero at the configured limit; an overflowing increment also wraps.
        seq <= (seq_inc >= {1'b0, cfg.max_seq_num}) ? '0 : seq_inc[SEQ_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      slot_r  <= slot;
      elem_r  <= element;
      value_r <= update_value;
      end_r   <= message_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_slot     <= slot_r;
      out_element  <= emit_idx;
      sum_value    <= acc_rdata;
      sequence_res <= seq;
      run_end      <= emit_last;
    end
  end

endmodule

// ===== sv/slot_sum_aggregator.sv =====
// Slot sum aggregator.
// Input channel (in_valid/in_stall): one item is one signed update element of a
// worker message, with its slot, element index and a message_end mark. It is
// accepted on a rising edge where in_valid is high and in_stall is low.
// The accumulator and message count memories are read in the accept cycle
// and written back in the next, so the block accepts no new item until this
// read-modify-write of the last one is done.
// When a message end brings a slot's count to num_workers, the block emits all
// elements in use (twice num_updates, at most 64) on the output channel
// (out_valid/out_stall), one per ST_EMIT_RD/ST_EMIT_OUT pass, reading and
// zeroing one accumulator per step; input stays stalled until the last
// element is loaded. The first element of a completion is read after the
// completing item's write-back, and loaded in ST_EMIT_OUT when the output is free.
// The output register holds a result while out_stall is high; the read
// sequence waits for it and nothing is lost or repeated.
// Configuration (cfg_we, cfg_index, cfg_data) is to be written by the user
// only while the block idles; the block does not enforce this. After reset
// it clears all 16384 accumulator entries and message counts, in_stall high.
module slot_sum_aggregator import ssa_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [SLOT_W-1:0]        slot,
  input  logic [ELEM_W-1:0]        element,
  input  logic signed [DATA_W-1:0] update_value,
  input  logic                     message_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [SLOT_W-1:0]        out_slot,
  output logic [ELEM_W-1:0]        out_element,
  output logic signed [DATA_W-1:0] sum_value,
  output logic [SEQ_W-1:0]         sequence_res,
  output logic                     run_end
);

  cfg_t cfg;
  logic [DATA_W-1:0] sum_raw;

  // Configuration registers; an index beyond the three registers is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.num_workers <= NUM_WORKERS_RST;
      cfg.num_updates <= NUM_UPDATES_RST;
      cfg.max_seq_num <= MAX_SEQ_NUM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_WORKERS: cfg.num_workers <= cfg_data[WORKERS_W-1:0];
        CFG_NUM_UPDATES: cfg.num_updates <= cfg_data[UPDATES_W-1:0];
        CFG_MAX_SEQ_NUM: cfg.max_seq_num <= cfg_data[SEQ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ssa_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .slot         (slot),
    .element      (element),
    .update_value (DATA_W'(unsigned'(update_value))),
    .message_end  (message_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_slot     (out_slot),
    .out_element  (out_element),
    .sum_value    (sum_raw),
    .sequence_res (sequence_res),
    .run_end      (run_end)
  );

  assign sum_value = signed'(sum_raw);

endmodule
